@@ rtl/core/npac_pkg.sv @@
// Shared types, constants and calibration tables for the Newton ADC correction core.
package npac_pkg;

	localparam int ROM_DEPTH      = 32;
	localparam int ROM_AW         = 5;
	localparam int NODE_COUNT_DEF = 15;
	localparam int CODE_W         = 12;
	localparam logic [63:0] DBL_ONE = 64'h3FF0_0000_0000_0000;

	localparam logic [63:0] ROM_X [ROM_DEPTH] = '{
		$realtobits(1550.000), $realtobits(1600.000), $realtobits(1749.295),
		$realtobits(1898.591), $realtobits(2059.909), $realtobits(2196.409),
		$realtobits(2394.955), $realtobits(2556.273), $realtobits(2655.545),
		$realtobits(2779.636), $realtobits(2965.773), $realtobits(3139.500),
		$realtobits(3251.182), $realtobits(3338.045), $realtobits(3412.500),
		64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
		64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
	};

	localparam logic [63:0] ROM_Y [ROM_DEPTH] = '{
		$realtobits(500.000), $realtobits(952.880), $realtobits(1166.999),
		$realtobits(1355.661), $realtobits(1544.700), $realtobits(1815.428),
		$realtobits(2072.718), $realtobits(2276.686), $realtobits(2467.859),
		$realtobits(2627.246), $realtobits(2836.527), $realtobits(2982.520),
		$realtobits(3121.189), $realtobits(3218.496), $realtobits(3317.580),
		64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
		64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
	};

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_CVT
	} fpu_op_t;

	typedef struct packed {
		fpu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_MUL,
		FS_DIV,
		FS_NORM,
		FS_ROUND
	} fpu_state_t;

	typedef enum logic [3:0] {
		CS_FILL,
		CS_DEN,
		CS_LO,
		CS_NUM,
		CS_DIV,
		CS_IDLE,
		CS_CVT,
		CS_DIFF,
		CS_PROD,
		CS_TERM,
		CS_ACC,
		CS_DONE
	} ctrl_state_t;

	function automatic logic [63:0] rom_x(input logic [ROM_AW-1:0] k);
		return ROM_X[k];
	endfunction

	function automatic logic [63:0] rom_y(input logic [ROM_AW-1:0] k);
		return ROM_Y[k];
	endfunction

endpackage

@@ rtl/core/npac_fpu.sv @@
// Iterative double-precision unit: add, subtract, multiply, divide, 12-bit convert.
module npac_fpu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  npac_pkg::fpu_req_t req,
	output logic              done,
	output logic [63:0]       result
);
	import npac_pkg::*;

	fpu_state_t          st_q, st_d;
	logic [109:0]        m_q;
	logic signed [12:0]  e_q;
	logic                s_q;
	logic                sticky_q;
	logic [52:0]         ma_q, mb_q;
	logic [54:0]         rem_q;
	logic [55:0]         quo_q;
	logic [5:0]          cnt_q;
	logic [63:0]         res_q;
	logic                done_q;

	logic                sa, sb, sb_eff, eff_sub, a_ge;
	logic [10:0]         ea, eb, eau, ebu, e_big, e_sml, dsh;
	logic [52:0]         ma, mb, m_big, m_sml;
	logic                s_big, b_zero;
	logic [108:0]        sml_ext, sml_sh;
	logic                lost;
	logic [109:0]        big_ext, al_ext, sum;
	logic [109:0]        mul_nxt;
	logic                div_ge;
	logic [54:0]         div_r1;
	logic [52:0]         rnd_mant;
	logic                rnd_g, rnd_st, rnd_up;
	logic [53:0]         rnd_mr;
	logic signed [12:0]  rnd_e;
	logic [52:0]         rnd_mf;

	always_comb begin
		sa  = req.a[63];
		sb  = req.b[63];
		ea  = req.a[62:52];
		eb  = req.b[62:52];
		ma  = {ea != 11'd0, req.a[51:0]};
		mb  = {eb != 11'd0, req.b[51:0]};
		eau = (ea == 11'd0) ? 11'd1 : ea;
		ebu = (eb == 11'd0) ? 11'd1 : eb;
		b_zero  = (req.b[62:0] == 63'd0);
		sb_eff  = sb ^ (req.op == OP_SUB);
		eff_sub = sa ^ sb_eff;
		a_ge    = {eau, ma} >= {ebu, mb};
		e_big   = a_ge ? eau : ebu;
		e_sml   = a_ge ? ebu : eau;
		m_big   = a_ge ? ma : mb;
		m_sml   = a_ge ? mb : ma;
		s_big   = a_ge ? sa : sb_eff;
		dsh     = e_big - e_sml;
		sml_ext = {m_sml, 56'd0};
		if (dsh >= 11'd109) begin
			sml_sh = '0;
			lost   = (m_sml != 53'd0);
		end else begin
			sml_sh = sml_ext >> dsh;
			lost   = ((sml_sh << dsh) != sml_ext);
		end
		big_ext = {1'b0, m_big, 56'd0};
		al_ext  = {1'b0, sml_sh[108:1], sml_sh[0] | lost};
		sum     = eff_sub ? (big_ext - al_ext) : (big_ext + al_ext);
	end

	always_comb begin
		mul_nxt = {m_q[108:0], 1'b0} + (ma_q[52] ? {57'd0, mb_q} : 110'd0);
		div_ge  = rem_q >= {2'b0, mb_q};
		div_r1  = div_ge ? (rem_q - {2'b0, mb_q}) : rem_q;
	end

	always_comb begin
		rnd_mant = m_q[108:56];
		rnd_g    = m_q[55];
		rnd_st   = (|m_q[54:0]) | sticky_q;
		rnd_up   = rnd_g & (rnd_st | rnd_mant[0]);
		rnd_mr   = {1'b0, rnd_mant} + {53'd0, rnd_up};
		if (rnd_mr[53]) begin
			rnd_mf = rnd_mr[53:1];
			rnd_e  = e_q + 13'sd1;
		end else begin
			rnd_mf = rnd_mr[52:0];
			rnd_e  = e_q;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			FS_IDLE: begin
				if (start) begin
					unique case (req.op)
						OP_MUL:  st_d = FS_MUL;
						OP_DIV:  st_d = b_zero ? FS_IDLE : FS_DIV;
						default: st_d = FS_NORM;
					endcase
				end
			end
			FS_MUL:   if (cnt_q == 6'd0) st_d = FS_NORM;
			FS_DIV:   if (cnt_q == 6'd0) st_d = FS_NORM;
			FS_NORM:  begin
				if (m_q == 110'd0)
					st_d = FS_IDLE;
				else if (!m_q[109] && m_q[108])
					st_d = FS_ROUND;
			end
			FS_ROUND: st_d = FS_IDLE;
			default:  st_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= FS_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= 1'b0;
			if (st_q == FS_IDLE && start && req.op == OP_DIV && b_zero)
				done_q <= 1'b1;
			if (st_q == FS_NORM && m_q == 110'd0)
				done_q <= 1'b1;
			if (st_q == FS_ROUND)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			FS_IDLE: begin
				if (start) begin
					sticky_q <= 1'b0;
					unique case (req.op)
						OP_CVT: begin
							m_q <= {2'b0, req.a[CODE_W-1:0], 96'd0};
							e_q <= 13'sd1035;
							s_q <= 1'b0;
						end
						OP_MUL: begin
							m_q   <= '0;
							ma_q  <= ma;
							mb_q  <= mb;
							cnt_q <= 6'd52;
							s_q   <= sa ^ sb;
							e_q   <= $signed({2'b0, eau}) + $signed({2'b0, ebu}) - 13'sd1023;
						end
						OP_DIV: begin
							res_q <= 64'd0;
							rem_q <= {2'b0, ma};
							mb_q  <= mb;
							quo_q <= '0;
							cnt_q <= 6'd55;
							s_q   <= sa ^ sb;
							e_q   <= $signed({2'b0, eau}) - $signed({2'b0, ebu}) + 13'sd1023;
						end
						default: begin
							m_q <= sum;
							e_q <= $signed({2'b0, e_big});
							s_q <= (eff_sub && sum == 110'd0) ? 1'b0 : s_big;
						end
					endcase
				end
			end
			FS_MUL: begin
				ma_q  <= {ma_q[51:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0)
					m_q <= {mul_nxt[105:0], 4'd0};
				else
					m_q <= mul_nxt;
			end
			FS_DIV: begin
				quo_q <= {quo_q[54:0], div_ge};
				rem_q <= {div_r1[53:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					m_q      <= {1'b0, quo_q[54:0], div_ge, 53'd0};
					sticky_q <= (div_r1 != 55'd0);
				end
			end
			FS_NORM: begin
				if (m_q == 110'd0) begin
					res_q <= {s_q, 63'd0};
				end else if (m_q[109]) begin
					m_q      <= {1'b0, m_q[109:1]};
					sticky_q <= sticky_q | m_q[0];
					e_q      <= e_q + 13'sd1;
				end else if (!m_q[108]) begin
					m_q <= {m_q[108:0], 1'b0};
					e_q <= e_q - 13'sd1;
				end
			end
			FS_ROUND: begin
				if (rnd_e >= 13'sd2047)
					res_q <= {s_q, 11'h7FF, 52'd0};
				else if (rnd_e <= 13'sd0)
					res_q <= {s_q, 63'd0};
				else
					res_q <= {s_q, rnd_e[10:0], rnd_mf[51:0]};
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ rtl/core/npac_ctrl.sv @@
// Sequencer: start-up divided-difference table and per-sample Newton evaluation.
module npac_ctrl #(
	parameter int NODE_COUNT = npac_pkg::NODE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_go,
	input  logic [npac_pkg::CODE_W-1:0] in_code,
	output logic                        idle,
	output logic                        res_valid,
	input  logic                        res_ack,
	output logic [63:0]                 res_data,
	output logic                        fpu_start,
	output npac_pkg::fpu_req_t          fpu_req,
	input  logic                        fpu_done,
	input  logic [63:0]                 fpu_result
);
	import npac_pkg::*;

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NODE_COUNT - 1);

	ctrl_state_t      state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, rd_addr, xi;
	logic             wait_q;
	logic [63:0]      mem_q [NODE_COUNT];
	logic [63:0]      rd_data_q;
	logic [CODE_W-1:0] code_q;
	logic [63:0]      t1_q, den_q, num_q, sample_q, acc_q, prod_q, tmp_q;
	logic             op_state;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_FILL: if (i_q == LAST) state_d = CS_DEN;
			CS_DEN:  if (fpu_done) state_d = CS_LO;
			CS_LO:   state_d = CS_NUM;
			CS_NUM:  if (fpu_done) state_d = CS_DIV;
			CS_DIV: begin
				if (fpu_done)
					state_d = (i_q == j_q && j_q == LAST) ? CS_IDLE : CS_DEN;
			end
			CS_IDLE: if (in_go) state_d = CS_CVT;
			CS_CVT:  if (fpu_done) state_d = CS_DIFF;
			CS_DIFF: if (fpu_done) state_d = CS_PROD;
			CS_PROD: if (fpu_done) state_d = CS_TERM;
			CS_TERM: if (fpu_done) state_d = CS_ACC;
			CS_ACC:  if (fpu_done) state_d = (i_q == LAST) ? CS_DONE : CS_DIFF;
			CS_DONE: if (res_ack) state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		op_state   = 1'b0;
		fpu_req.op = OP_ADD;
		fpu_req.a  = '0;
		fpu_req.b  = '0;
		rd_addr    = i_q;
		xi         = i_q - j_q;
		unique case (state_q)
			CS_DEN: begin
				op_state   = 1'b1;
				fpu_req.op = OP_SUB;
				fpu_req.a  = rom_x(ROM_AW'(i_q));
				fpu_req.b  = rom_x(ROM_AW'(xi));
			end
			CS_LO: rd_addr = i_q - IDX_W'(1);
			CS_NUM: begin
				op_state   = 1'b1;
				rd_addr    = i_q - IDX_W'(1);
				fpu_req.op = OP_SUB;
				fpu_req.a  = t1_q;
				fpu_req.b  = rd_data_q;
			end
			CS_DIV: begin
				op_state   = 1'b1;
				fpu_req.op = OP_DIV;
				fpu_req.a  = num_q;
				fpu_req.b  = den_q;
			end
			CS_CVT: begin
				op_state   = 1'b1;
				fpu_req.op = OP_CVT;
				fpu_req.a  = {52'd0, code_q};
			end
			CS_DIFF: begin
				op_state   = 1'b1;
				fpu_req.op = OP_SUB;
				fpu_req.a  = sample_q;
				fpu_req.b  = rom_x(ROM_AW'(i_q - IDX_W'(1)));
			end
			CS_PROD: begin
				op_state   = 1'b1;
				fpu_req.op = OP_MUL;
				fpu_req.a  = prod_q;
				fpu_req.b  = tmp_q;
			end
			CS_TERM: begin
				op_state   = 1'b1;
				fpu_req.op = OP_MUL;
				fpu_req.a  = rd_data_q;
				fpu_req.b  = prod_q;
			end
			CS_ACC: begin
				op_state   = 1'b1;
				fpu_req.op = OP_ADD;
				fpu_req.a  = acc_q;
				fpu_req.b  = tmp_q;
			end
			default: ;
		endcase
		fpu_start = op_state && !wait_q;
		idle      = (state_q == CS_IDLE);
		res_valid = (state_q == CS_DONE);
		res_data  = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_FILL;
			wait_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (fpu_start)
				wait_q <= 1'b1;
			else if (fpu_done)
				wait_q <= 1'b0;
			unique case (state_q)
				CS_FILL: begin
					if (i_q == LAST)
						j_q <= IDX_W'(1);
					else
						i_q <= i_q + IDX_W'(1);
				end
				CS_DIV: begin
					if (fpu_done) begin
						if (i_q == j_q) begin
							j_q <= j_q + IDX_W'(1);
							i_q <= LAST;
						end else begin
							i_q <= i_q - IDX_W'(1);
						end
					end
				end
				CS_IDLE: if (in_go) i_q <= '0;
				CS_CVT:  if (fpu_done) i_q <= IDX_W'(1);
				CS_ACC:  if (fpu_done && i_q != LAST) i_q <= i_q + IDX_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
		if (state_q == CS_FILL)
			mem_q[i_q] <= rom_y(ROM_AW'(i_q));
		if (state_q == CS_DIV && fpu_done)
			mem_q[i_q] <= fpu_result;
		if (state_q == CS_IDLE && in_go)
			code_q <= in_code;
		if (fpu_done) begin
			unique case (state_q)
				CS_DEN: begin
					den_q <= fpu_result;
					t1_q  <= rd_data_q;
				end
				CS_NUM: num_q <= fpu_result;
				CS_CVT: begin
					sample_q <= fpu_result;
					acc_q    <= rd_data_q;
					prod_q   <= DBL_ONE;
				end
				CS_DIFF: tmp_q  <= fpu_result;
				CS_PROD: prod_q <= fpu_result;
				CS_TERM: tmp_q  <= fpu_result;
				CS_ACC:  acc_q  <= fpu_result;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/newton_polynomial_adc_correction_core.sv @@
// Newton-polynomial ADC correction core: handshake, output register, sequencer and FPU.
// Per sample: one convert, then (NODE_COUNT-1) rounds of sub, two mul and add on the shared FPU.
// Throughput: one transaction at a time; in_stall is high until the result is handed off.
// Reset: NODE_COUNT entries filled, then the table is rebuilt in NODE_COUNT*(NODE_COUNT-1)/2
// sub/sub/div steps; in_stall is high until done.
module newton_polynomial_adc_correction_core #(
	parameter int NODE_COUNT = npac_pkg::NODE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [npac_pkg::CODE_W-1:0] adc_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [63:0]                 corrected_value
);
	import npac_pkg::*;

	logic        idle, res_valid, res_ack, in_go;
	logic [63:0] res_data;
	logic        fpu_start, fpu_done;
	fpu_req_t    fpu_req;
	logic [63:0] fpu_result;
	logic        out_valid_q;
	logic [63:0] out_data_q;

	assign in_stall = !idle;
	assign in_go    = in_valid && idle;
	assign res_ack  = res_valid && (!out_valid_q || !out_stall);

	npac_ctrl #(.NODE_COUNT(NODE_COUNT)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_go      (in_go),
		.in_code    (adc_code),
		.idle       (idle),
		.res_valid  (res_valid),
		.res_ack    (res_ack),
		.res_data   (res_data),
		.fpu_start  (fpu_start),
		.fpu_req    (fpu_req),
		.fpu_done   (fpu_done),
		.fpu_result (fpu_result)
	);

	npac_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fpu_start),
		.req    (fpu_req),
		.done   (fpu_done),
		.result (fpu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_ack)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack)
			out_data_q <= res_data;
	end

	assign out_valid       = out_valid_q;
	assign corrected_value = out_data_q;

endmodule

@@ sim/npac_checker.sv @@
// Scoreboard for the Newton ADC correction core: predicts each correction and compares results.
`timescale 1ns / 1ps
module npac_checker #(
	parameter int NODE_COUNT = npac_pkg::NODE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [npac_pkg::CODE_W-1:0] adc_code,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [63:0]                 corrected_value,
	output int                          errors,
	output int                          pending
);
	import npac_pkg::*;

	real         node_x [ROM_DEPTH];
	real         newton_coef [ROM_DEPTH];
	logic [63:0] expected_values [$];

	function automatic int node_total();
		int n;
		n = NODE_COUNT;
		if (n < 1) n = 1;
		if (n > ROM_DEPTH) n = ROM_DEPTH;
		return n;
	endfunction

	function automatic void build_coefficients();
		real col [ROM_DEPTH];
		real den;
		real num;
		int  n;
		n = node_total();
		for (int i = 0; i < ROM_DEPTH; i++) begin
			node_x[i] = $bitstoreal(ROM_X[i]);
			col[i] = (i < n) ? $bitstoreal(ROM_Y[i]) : 0.0;
			newton_coef[i] = 0.0;
		end
		newton_coef[0] = col[0];
		for (int j = 1; j < n; j++) begin
			for (int i = n - 1; i >= j; i--) begin
				den = node_x[i] - node_x[i - j];
				num = col[i] - col[i - 1];
				col[i] = (den != 0.0) ? num / den : 0.0;
			end
			newton_coef[j] = col[j];
		end
	endfunction

	function automatic logic [63:0] correct_code(input logic [CODE_W-1:0] code);
		real s;
		real acc;
		real prod;
		s = real'(code);
		acc = newton_coef[0];
		prod = 1.0;
		for (int i = 1; i < node_total(); i++) begin
			prod = prod * (s - node_x[i - 1]);
			acc = acc + newton_coef[i] * prod;
		end
		return $realtobits(acc);
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
	endtask

	initial begin
		build_coefficients();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_values.push_back(correct_code(adc_code));
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0)
					report("unexpected transaction", corrected_value, 64'h0);
				else if (corrected_value !== expected_values[0])
					report("corrected_value", corrected_value, expected_values.pop_front());
				else
					void'(expected_values.pop_front());
			end
		end
		pending = expected_values.size();
	end

endmodule

@@ sim/newton_polynomial_adc_correction_core_tb.sv @@
// Testbench top for the Newton ADC correction core: stimulus, stall bursts and verdict.
`timescale 1ns / 1ps
module newton_polynomial_adc_correction_core_tb;
	import npac_pkg::*;

	localparam int  RANDOM_ITEMS = 830;
	localparam int  QUIET_ITEMS  = 100;
	localparam longint CYCLE_LIMIT = 64'd40_000_000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CODE_W-1:0] adc_code = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [63:0]       corrected_value;
	int                errors;
	int                pending;
	bit                quiet = 1'b0;
	int                stall_left = 0;
	longint            cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	newton_polynomial_adc_correction_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .adc_code(adc_code),
		.out_valid(out_valid), .out_stall(out_stall), .corrected_value(corrected_value)
	);

	npac_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .adc_code(adc_code),
		.out_valid(out_valid), .out_stall(out_stall), .corrected_value(corrected_value),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(3) == 0) begin
			stall_left <= $urandom_range(9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_code(input logic [CODE_W-1:0] code);
		int gap;
		bit go;
		if (!quiet && $urandom_range(3) == 0) begin
			gap = $urandom_range(10, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_code <= code;
		forever begin
			@(negedge clk);
			go = !in_stall;
			@(posedge clk);
			if (go) break;
		end
	endtask

	initial begin
		logic [CODE_W-1:0] directed [$];
		logic [CODE_W-1:0] code;
		directed = '{12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2048, 12'd2047,
			12'hAAA, 12'h555, 12'd1550, 12'd1549, 12'd1600, 12'd1749,
			12'd2060, 12'd2656, 12'd3139, 12'd3140, 12'd3412, 12'd3413,
			12'd3414, 12'd1000, 12'd3800};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[k]) send_code(directed[k]);
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
			case ($urandom_range(3))
				0: code = CODE_W'($urandom_range(3412, 1550));
				1: code = CODE_W'($rtoi($bitstoreal(ROM_X[$urandom_range(14)]))
					+ int'($urandom_range(4)) - 2);
				default: code = CODE_W'($urandom);
			endcase
			send_code(code);
		end
		in_valid <= 1'b0;
		quiet = 1'b1;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
